FILE: hw/rtl/utf8_stream_decoder_unit_macros.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define U8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define U8SD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8SD_ASSERT(label, prop, msg)
`define U8SD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hw/rtl/u8sd_pkg.sv
// Types and constants shared by the UTF-8 stream decoder modules.
package u8sd_pkg;

  localparam int CP_W = 21;
  localparam int RUN_W = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // One queue entry: a run of results for one byte. All beats of the run but
  // the last carry the replacement character; the last carries tail.
  typedef struct packed {
    logic [RUN_W-1:0] count;
    logic [CP_W-1:0]  tail;
    logic             eot;
  } u8sd_run_t;

endpackage

FILE: hw/rtl/u8sd_front.sv
// Front end: accepts text bytes, tracks the pending sequence, queues result runs.
module u8sd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  input  logic                 q_full,
  output logic                 push,
  output u8sd_pkg::u8sd_run_t  push_run
);
  import u8sd_pkg::*;

  logic [1:0]      bytes_expected;
  logic [1:0]      bytes_taken;
  logic [CP_W-1:0] partial_value;
  logic [1:0]      bytes_expected_next;
  logic [1:0]      bytes_taken_next;
  logic [CP_W-1:0] partial_value_next;

  logic [RUN_W-1:0] run_count;
  logic [CP_W-1:0]  run_tail;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic            consumed;
    logic            is_cont;
    logic [1:0]      taken_inc;
    logic [CP_W-1:0] shifted;
    consumed            = 1'b0;
    is_cont             = (text_byte[7:6] == 2'b10);
    taken_inc           = bytes_taken + 2'd1;
    shifted             = {partial_value[CP_W-7:0], text_byte[5:0]};
    run_count           = '0;
    run_tail            = REPL_CP;
    bytes_expected_next = bytes_expected;
    bytes_taken_next    = bytes_taken;
    partial_value_next  = partial_value;

    if (bytes_expected != 2'd0) begin
      if (is_cont) begin
        consumed = 1'b1;
        if (taken_inc >= bytes_expected) begin
          run_count           = RUN_W'(1);
          run_tail            = shifted;
          bytes_expected_next = 2'd0;
          bytes_taken_next    = 2'd0;
          partial_value_next  = '0;
        end else if (end_of_text) begin
          // Lead and every continuation so far each turn into a replacement.
          run_count           = RUN_W'(taken_inc) + RUN_W'(1);
          bytes_expected_next = 2'd0;
          bytes_taken_next    = 2'd0;
          partial_value_next  = '0;
        end else begin
          bytes_taken_next   = taken_inc;
          partial_value_next = shifted;
        end
      end else begin
        run_count           = RUN_W'(bytes_taken) + RUN_W'(1);
        bytes_expected_next = 2'd0;
        bytes_taken_next    = 2'd0;
        partial_value_next  = '0;
      end
    end

    if (!consumed) begin
      priority if (text_byte[7] == 1'b0) begin
        run_count = run_count + RUN_W'(1);
        run_tail  = CP_W'(text_byte);
      end else if (text_byte[7:5] == 3'b110) begin
        bytes_expected_next = 2'd1;
        bytes_taken_next    = 2'd0;
        partial_value_next  = CP_W'(text_byte[4:0]);
      end else if (text_byte[7:4] == 4'b1110) begin
        bytes_expected_next = 2'd2;
        bytes_taken_next    = 2'd0;
        partial_value_next  = CP_W'(text_byte[3:0]);
      end else if (text_byte[7:3] == 5'b11110) begin
        bytes_expected_next = 2'd3;
        bytes_taken_next    = 2'd0;
        partial_value_next  = CP_W'(text_byte[2:0]);
      end else begin
        run_count = run_count + RUN_W'(1);
        run_tail  = REPL_CP;
      end
      if (end_of_text && bytes_expected_next != 2'd0) begin
        run_count = run_count + RUN_W'(1);
        run_tail  = REPL_CP;
      end
    end

    if (end_of_text) begin
      bytes_expected_next = 2'd0;
      bytes_taken_next    = 2'd0;
      partial_value_next  = '0;
    end
  end

  assign push           = accept && (run_count != '0);
  assign push_run.count = run_count;
  assign push_run.tail  = run_tail;
  assign push_run.eot   = end_of_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_taken    <= 2'd0;
      partial_value  <= '0;
    end else if (accept) begin
      bytes_expected <= bytes_expected_next;
      bytes_taken    <= bytes_taken_next;
      partial_value  <= partial_value_next;
    end
  end

endmodule

FILE: hw/rtl/u8sd_queue.sv
// Short queue of result runs between the front and the back end.
`include "utf8_stream_decoder_unit_macros.svh"

module u8sd_queue #(
  parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  u8sd_pkg::u8sd_run_t  push_run,
  input  logic                 pop,
  output u8sd_pkg::u8sd_run_t  pop_run,
  output logic                 full,
  output logic                 empty
);
  import u8sd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  u8sd_run_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign full    = (level == LVL_W'(DEPTH));
  assign empty   = (level == '0);
  assign pop_run = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  `U8SD_ASSERT(a_no_push_full, push |-> !full, "push into a full queue")
  `U8SD_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from an empty queue")
  `U8SD_ASSERT(a_level_up, push && !pop |=> level == $past(level) + LVL_W'(1), "level did not rise")

endmodule

FILE: hw/rtl/u8sd_back.sv
// Back end: expands each queued run into result beats on the output channel.
`include "utf8_stream_decoder_unit_macros.svh"

module u8sd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  u8sd_pkg::u8sd_run_t          pop_run,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8sd_pkg::CP_W-1:0]    code_point,
  output logic                         last_of_run,
  output logic                         text_done
);
  import u8sd_pkg::*;

  logic             busy;
  logic [RUN_W-1:0] remaining;
  logic [CP_W-1:0]  tail;
  logic             eot;
  logic             on_last;

  assign on_last     = (remaining == RUN_W'(1));
  assign out_valid   = busy;
  assign code_point  = on_last ? tail : REPL_CP;
  assign last_of_run = on_last;
  assign text_done   = on_last && eot;

  // A new run loads as the final beat of the current one goes out.
  assign pop = !q_empty && (!busy || (out_ready && on_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= pop_run.count;
    end else if (busy && out_ready) begin
      remaining <= remaining - RUN_W'(1);
      if (on_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tail <= pop_run.tail;
      eot  <= pop_run.eot;
    end
  end

  `U8SD_ASSERT(a_busy_has_beats, busy |-> remaining != '0, "busy with no beats left")
  `U8SD_ASSERT(a_done_is_last, text_done |-> last_of_run, "text_done off the last beat")
  `U8SD_ASSERT(a_lead_beats_repl, out_valid && !last_of_run |-> code_point == REPL_CP, "early beat not U+FFFD")

endmodule

FILE: hw/rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: front end, run queue and back end.
// Each byte's results pass through the run queue, then the back end's run registers, to the output.
// Throughput: one byte per cycle while the queue has room; a byte's k results give k beats.
// A queue of QUEUE_DEPTH runs lets the input keep flowing while runs drain; it stalls when full.
// Reset (synchronous, active high) clears the pending sequence, the queue and the output.
// No clearing pass is needed after reset.
module utf8_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 text_byte,
  input  logic                       end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8sd_pkg::CP_W-1:0]  code_point,
  output logic                       last_of_run,
  output logic                       text_done
);
  import u8sd_pkg::*;

  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  u8sd_run_t push_run;
  u8sd_run_t pop_run;

  u8sd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .push_run    (push_run)
  );

  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .pop_run  (pop_run),
    .full     (q_full),
    .empty    (q_empty)
  );

  u8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop_run     (pop_run),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

endmodule

FILE: bench/utf8_stream_decoder_unit_tb.sv
// Self-checking bench for the UTF-8 stream decoder: directed and random byte streams.
module utf8_stream_decoder_unit_tb;
  import u8sd_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
    logic            done;
  } decoded_cp_t;

  // Tracks the pending sequence and holds the code points still owed by the block.
  class utf8_scoreboard;
    logic [1:0]      need;
    logic [1:0]      taken;
    logic [CP_W-1:0] bits;
    decoded_cp_t     expected_q[$];
    int              errors;

    function new();
      clear_seq();
      errors = 0;
    endfunction

    function void clear_seq();
      need = 2'd0;
      taken = 2'd0;
      bits = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      decoded_cp_t run_q[$];
      decoded_cp_t plain;
      decoded_cp_t repl;
      bit          consumed;
      plain = '0;
      repl = '0;
      repl.cp = REPL_CP;
      consumed = 0;
      if (need != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          bits = {bits[CP_W-7:0], b[5:0]};
          taken = taken + 2'd1;
          if (taken >= need) begin
            plain.cp = bits;
            run_q = {run_q, plain};
            clear_seq();
          end else if (eot) begin
            // The lead and every continuation taken so far each turn into U+FFFD.
            repeat (int'(taken) + 1) run_q = {run_q, repl};
            clear_seq();
          end
          consumed = 1;
        end else begin
          repeat (int'(taken) + 1) run_q = {run_q, repl};
          clear_seq();
        end
      end
      if (!consumed) begin
        if (b[7] == 1'b0) begin
          plain.cp = CP_W'(b[6:0]);
          run_q = {run_q, plain};
        end else if (b[7:5] == 3'b110) begin
          need = 2'd1;
          taken = 2'd0;
          bits = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          need = 2'd2;
          taken = 2'd0;
          bits = CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          need = 2'd3;
          taken = 2'd0;
          bits = CP_W'(b[2:0]);
        end else begin
          run_q = {run_q, repl};
        end
        if (eot && need != 2'd0) begin
          run_q = {run_q, repl};
          clear_seq();
        end
      end
      if (eot) clear_seq();
      if (run_q.size() > 0) begin
        run_q[$].last = 1'b1;
        if (eot) run_q[$].done = 1'b1;
      end
      foreach (run_q[i]) expected_q = {expected_q, run_q[i]};
    endfunction

    function void check_result(logic [CP_W-1:0] cp, logic last, logic done);
      decoded_cp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got cp %h last %b done %b",
                 $time, cp, last, done);
        return;
      end
      want = expected_q.pop_front();
      if (cp !== want.cp) begin
        errors++;
        $display("%0t: code_point expected %h got %h", $time, want.cp, cp);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run expected %b got %b", $time, want.last, last);
      end
      if (done !== want.done) begin
        errors++;
        $display("%0t: text_done expected %b got %b", $time, want.done, done);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      text_byte = 8'h00;
  logic            end_of_text = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CP_W-1:0] code_point;
  logic            last_of_run;
  logic            text_done;

  utf8_scoreboard sb = new();
  text_beat_t     stim_q[$];
  bit             ready_phase = 1'b0;
  int             hold_cnt = 0;

  utf8_stream_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // All inputs change by nonblocking assignment, so the values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(text_byte, end_of_text);
      if (out_valid && out_ready) sb.check_result(code_point, last_of_run, text_done);
    end
  end

  // Receiver alternates ready runs with stalls, now and then a long one.
  always @(posedge clk) begin
    if (hold_cnt == 0) begin
      ready_phase = !ready_phase;
      if (ready_phase) hold_cnt = $urandom_range(1, 24);
      else if ($urandom_range(0, 7) == 0) hold_cnt = $urandom_range(10, 30);
      else hold_cnt = $urandom_range(1, 4);
    end
    hold_cnt--;
    out_ready <= ready_phase;
  end

  function automatic void push_byte(logic [7:0] b, logic eot);
    text_beat_t beat;
    beat.b = b;
    beat.eot = eot;
    stim_q = {stim_q, beat};
  endfunction

  function automatic logic [7:0] lead_for(int len);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (len)
      1: r[7] = 1'b0;
      2: r[7:5] = 3'b110;
      3: r[7:4] = 4'b1110;
      default: r[7:3] = 5'b11110;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic build_random(int count);
    int stop;
    int kind;
    int len;
    int conts;
    logic [7:0] b;
    stop = stim_q.size() + count;
    while (stim_q.size() < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(1, 4);
        push_byte(lead_for(len), 1'b0);
        repeat (len - 1) push_byte(cont_byte(), 1'b0);
        if ($urandom_range(0, 7) == 0) stim_q[$].eot = 1'b1;
      end else if (kind < 85) begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        // Sequence cut short, either by a non-continuation byte or by end of text.
        len = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        push_byte(lead_for(len), 1'b0);
        repeat (conts) push_byte(cont_byte(), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          stim_q[$].eot = 1'b1;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
          push_byte(b, $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  task automatic send_range(int first, int stop);
    int idx;
    int burst;
    int gap;
    idx = first;
    while (idx < stop) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      while (burst > 0 && idx < stop) begin
        in_valid <= 1'b1;
        text_byte <= stim_q[idx].b;
        end_of_text <= stim_q[idx].eot;
        do @(posedge clk); while (!in_ready);
        idx++;
        burst--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    // Let the monitor note the byte accepted at the current edge first.
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    // A byte with no result may still be in flight; give it the pipeline latency.
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int directed_n;
    int half;

    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
    // Largest value the four-byte form can carry.
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF8, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b1);
    push_byte(8'hE2, 1'b0); push_byte(8'hC3, 1'b1);
    push_byte(8'h7F, 1'b1);
    directed_n = stim_q.size();
    build_random(135);
    half = directed_n + (stim_q.size() - directed_n) / 2;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_range(0, directed_n);
    wait_drained();
    send_range(directed_n, half);
    wait_drained();
    send_range(half, stim_q.size());
    wait_drained();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS utf8_stream_decoder_unit");
    end else begin
      $display("FAIL utf8_stream_decoder_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL utf8_stream_decoder_unit");
    $finish;
  end

endmodule
